// ===== hw/rtl/ets_pkg.sv =====
// Shared types, constants and a helper function for the event time surface unit.
`default_nettype none
package ets_pkg;

  // Default geometry and table size
  localparam int SENSOR_WIDTH_DEF    = 256;
  localparam int SENSOR_HEIGHT_DEF   = 256;
  localparam int EXP_TABLE_DEPTH_DEF = 1024;

  // Field widths
  localparam int TS_W       = 32;
  localparam int COORD_W    = 8;
  localparam int VALUE_W    = 8;
  localparam int DECAY_W    = 24;
  localparam int THR_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int EXP_W      = 17;   // Q1.16, 65536 is one
  // Divisor is 32 * decay: 24 + 5 bits
  localparam int DIV_W      = DECAY_W + 5;

  // Command codes
  localparam logic CMD_EVENT   = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_POL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;

  // Register reset values
  localparam logic [DECAY_W-1:0] DECAY_RST = 24'd50000;
  localparam logic [THR_W-1:0]   THR_RST   = 24'd0;

  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  // Readout constants
  localparam logic [VALUE_W-1:0] NEVER_SIGNED   = 8'd128;
  localparam logic [VALUE_W-1:0] NEVER_UNSIGNED = 8'd0;

  typedef struct packed {
    logic                 cmd;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic                 event_polarity;
    logic [TS_W-1:0]      timestamp_us;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   surface_value;
    logic                 event_stored;
  } result_t;

  // One memory word per pixel: both filtered and both raw stamps
  typedef struct packed {
    logic [TS_W-1:0] fpos;
    logic [TS_W-1:0] fneg;
    logic [TS_W-1:0] rpos;
    logic [TS_W-1:0] rneg;
  } stamp_word_t;

  // exp(-t) in Q1.31 from a Taylor series through the t^24 term, t in Q1.31
  function automatic logic [63:0] exp_sum(input logic [63:0] t);
    logic [63:0] s;
    logic [63:0] term;
    s    = Q31_ONE;
    term = Q31_ONE;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * t) >> 31) / 64'(k);
      if ((k % 2) == 1) s = s - term;
      else s = s + term;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ets_stamp_mem.sv =====
// Per-pixel stamp memory: one write port, one registered read port.
`default_nettype none
module ets_stamp_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  ets_pkg::stamp_word_t wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output ets_pkg::stamp_word_t rdata
);
  import ets_pkg::*;

  stamp_word_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, registered, enabled by re
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ets_exp_table.sv =====
// Exponential decay table: built entry by entry after reset, registered read.
`default_nettype none
module ets_exp_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       build_we,
  input  logic [AW-1:0]              build_addr,
  input  logic [AW-1:0]              rd_addr,
  output logic [ets_pkg::EXP_W-1:0]  rd_data
);
  import ets_pkg::*;

  // step exp(-16/DEPTH) in Q1.31
  localparam logic [63:0] STEP_T = ((64'd16 << 31) + 64'(DEPTH / 2)) / 64'(DEPTH);
  localparam logic [63:0] STEP_E = exp_sum(STEP_T);

  logic [EXP_W-1:0] mem [DEPTH];
  logic [31:0]      cur;
  logic [63:0]      prod;

  assign prod = 64'(cur) * 64'(STEP_E[31:0]);

  // running power of the step, one entry per build cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= Q31_ONE[31:0];
    end else if (build_we) begin
      cur <= prod[62:31];
    end
  end

  always_ff @(posedge clk) begin
    if (build_we) mem[build_addr] <= EXP_W'((33'(cur) + 33'd16384) >> 15);
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ets_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ets_divider #(
  parameter int NW = 47
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [NW-1:0]              numer,
  input  logic [ets_pkg::DIV_W-1:0]  denom,
  output logic                       done,
  output logic [NW-1:0]              quot
);
  import ets_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quot[NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  // shift numerator out, quotient in
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= CNT_W'(NW);
        quot <= numer;
        dvs  <= denom;
        rem  <= '0;
      end else if (run) begin
        rem  <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
        quot <= {quot[NW-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/event_time_surface_unit.sv =====
// Top level of the event time surface unit: control, configuration and readout maths.
// After reset the unit runs a clearing pass over max(SENSOR_WIDTH*SENSOR_HEIGHT,
// EXP_TABLE_DEPTH) addresses that zeroes the stamp memory and builds the decay
// table; busy is high meanwhile. An event word goes through a memory read, then
// a read-modify-write, and its result strobes in the same cycle that busy falls.
// A readout goes through the memory read, the eval step, the bit-serial divider
// that forms the table index (NW = 34 + clog2(depth + 1)) and a table read; a
// readout of a pixel that never fired or lies off the sensor ends at the eval step.
// Results appear for one cycle on result with result_valid and cannot be held
// off. Configuration writes are always accepted (cfg_ready is high).
`default_nettype none
module event_time_surface_unit #(
  parameter int SENSOR_WIDTH    = ets_pkg::SENSOR_WIDTH_DEF,
  parameter int SENSOR_HEIGHT   = ets_pkg::SENSOR_HEIGHT_DEF,
  parameter int EXP_TABLE_DEPTH = ets_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  ets_pkg::item_t                   item,
  output logic                             result_valid,
  output ets_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ets_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ets_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ets_pkg::*;

  localparam int PIXELS  = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int PAW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int TAW     = $clog2(EXP_TABLE_DEPTH);
  localparam int CLR_LEN = (PIXELS > EXP_TABLE_DEPTH) ? PIXELS : EXP_TABLE_DEPTH;
  localparam int CW      = $clog2(CLR_LEN + 1);
  localparam int NW      = 34 + $clog2(EXP_TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_MUL, S_DIV, S_TAB, S_OUT
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  item_t           it;
  logic            it_valid;
  logic [PAW-1:0]  pix;
  logic [TS_W-1:0] dt;
  logic            pos;
  logic            sat;
  logic [TAW-1:0]  tab_addr;

  logic [DECAY_W-1:0] decay_time_us;
  logic               ignore_polarity;
  logic [THR_W-1:0]   refractory_threshold_us;

  logic            accept;
  logic            in_valid;
  logic [PAW-1:0]  in_pix;

  logic            mem_we;
  logic [PAW-1:0]  mem_waddr;
  stamp_word_t     mem_wdata;
  stamp_word_t     rd;

  logic            tab_we;
  logic [EXP_W-1:0] tab_data;

  logic               div_go;
  logic               div_done;
  logic [NW-1:0]      div_numer;
  logic [DIV_W-1:0]   div_denom;
  logic [NW-1:0]      quot;
  logic [DECAY_W-1:0] decay_eff;

  // eval-stage values
  logic            sel_pos;
  logic [TS_W-1:0] stamp;
  logic [TS_W-1:0] last;
  logic [TS_W-1:0] other;
  logic            take;
  stamp_word_t     upd;

  // output maths
  logic [EXP_W-1:0] e;
  logic [24:0]      v_uns;
  logic [25:0]      v_pos;
  logic [25:0]      v_neg;
  logic [VALUE_W-1:0] value;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // pixel address of the incoming word
  assign in_valid = (32'(item.pixel_x) < 32'(SENSOR_WIDTH)) &&
                    (32'(item.pixel_y) < 32'(SENSOR_HEIGHT));
  assign in_pix   = PAW'(32'(item.pixel_y) * 32'(SENSOR_WIDTH) + 32'(item.pixel_x));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_time_us           <= DECAY_RST;
      ignore_polarity         <= 1'b0;
      refractory_threshold_us <= THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECAY:      decay_time_us           <= cfg_data;
        REG_IGNORE_POL: ignore_polarity         <= cfg_data[0];
        REG_THRESHOLD:  refractory_threshold_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // event read-modify-write
  always_comb begin
    sel_pos = rd.fpos > rd.fneg;
    stamp   = sel_pos ? rd.fpos : rd.fneg;
    last    = it.event_polarity ? rd.rpos : rd.rneg;
    other   = it.event_polarity ? rd.rneg : rd.rpos;
    take    = it_valid &&
              (((TS_W+1)'(it.timestamp_us) >
                (TS_W+1)'(last) + (TS_W+1)'(refractory_threshold_us)) || (other > last));
    upd = rd;
    if (it.event_polarity) begin
      upd.rpos = it.timestamp_us;
      if (take) upd.fpos = it.timestamp_us;
    end else begin
      upd.rneg = it.timestamp_us;
      if (take) upd.fneg = it.timestamp_us;
    end
  end

  // memory write port: clearing pass or event update
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = cnt < CW'(PIXELS);
      mem_waddr = cnt[PAW-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = (state == S_EVAL) && (it.cmd == CMD_EVENT) && it_valid;
      mem_waddr = pix;
      mem_wdata = upd;
    end
  end

  assign tab_we = (state == S_CLEAR) && (cnt < CW'(EXP_TABLE_DEPTH));

  // divider operands: index = (2*dt*D + 16*decay) / (32*decay)
  assign decay_eff = (decay_time_us == '0) ? DECAY_W'(1) : decay_time_us;
  assign div_go    = (state == S_MUL);
  assign div_numer = NW'(dt) * NW'(2 * EXP_TABLE_DEPTH) + (NW'(decay_eff) << 4);
  assign div_denom = DIV_W'(decay_eff) << 5;

  // value from the table entry
  always_comb begin
    e     = sat ? '0 : tab_data;
    v_uns = 25'(255) * 25'(e) + 25'd32768;
    v_pos = 26'(255) * (26'd65536 + 26'(e)) + 26'd65536;
    v_neg = 26'(255) * (26'd65536 - 26'(e)) + 26'd65536;
    if (ignore_polarity) value = v_uns[23:16];
    else if (pos) value = v_pos[24:17];
    else value = v_neg[24:17];
  end

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(CLR_LEN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            it       <= item;
            it_valid <= in_valid;
            pix      <= in_pix;
            state    <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (it.cmd == CMD_EVENT) begin
            result_valid         <= 1'b1;
            result.surface_value <= '0;
            result.event_stored  <= take;
            state                <= S_IDLE;
          end else if (!it_valid || stamp == '0) begin
            result_valid         <= 1'b1;
            result.surface_value <= ignore_polarity ? NEVER_UNSIGNED : NEVER_SIGNED;
            result.event_stored  <= 1'b0;
            state                <= S_IDLE;
          end else begin
            dt    <= (it.timestamp_us >= stamp) ? it.timestamp_us - stamp : '0;
            pos   <= sel_pos;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            sat      <= quot >= NW'(EXP_TABLE_DEPTH);
            tab_addr <= quot[TAW-1:0];
            state    <= S_TAB;
          end
        end
        S_TAB: state <= S_OUT;
        S_OUT: begin
          result_valid         <= 1'b1;
          result.surface_value <= value;
          result.event_stored  <= 1'b0;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ets_stamp_mem #(
    .DEPTH(PIXELS),
    .AW   (PAW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (accept),
    .raddr(in_pix),
    .rdata(rd)
  );

  ets_exp_table #(
    .DEPTH(EXP_TABLE_DEPTH),
    .AW   (TAW)
  ) u_tab (
    .clk       (clk),
    .rst       (rst),
    .build_we  (tab_we),
    .build_addr(cnt[TAW-1:0]),
    .rd_addr   (tab_addr),
    .rd_data   (tab_data)
  );

  ets_divider #(
    .NW(NW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .numer(div_numer),
    .denom(div_denom),
    .done (div_done),
    .quot (quot)
  );

  // a result comes only from the eval or output step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_EVAL || $past(state) == S_OUT))
    else $error("result without a finishing step");

  // the stamp memory is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("stamp write while idle");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done out of step");

  // a new word is never taken while a readout is in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_TAB) |=> (state != S_EVAL))
    else $error("item overlap");

endmodule
`default_nettype wire
